### hdl/sdd_pkg.sv
package sdd_pkg;

    // Port widths
    localparam int PHI_W   = 24;
    localparam int SIGMA_W = 23;
    localparam int OUT_W   = 23;

    // Internal fixed-point widths (Q30 cosine path)
    localparam int Q_FRAC  = 30;
    localparam int R_W     = 31;   // ratio |x|/sigma in Q1.30, up to 2^30
    localparam int U_W     = 30;   // folded ratio, up to 2^29
    localparam int V_W     = 29;   // u^2 in Q30, up to 2^28
    localparam int P_W     = 33;   // Horner partial, up to the largest coefficient
    localparam int C_W     = 32;   // 1 +/- cos in Q30, up to 2^31
    localparam int COS_STG = 8;    // register stages of the cosine unit

    localparam logic [SIGMA_W-1:0] SIGMA_RESET = 23'd98304;
    localparam logic [OUT_W-1:0]   OUT_MAX     = 23'd8388607;
    localparam logic [P_W-1:0]     Q30_ONE     = 33'd1073741824;
    localparam logic [R_W-1:0]     Q30_HALF    = 31'd536870912;

    // pi^(2k)/(2k)! in Q30, k = 1..6 (index 0 holds k = 1)
    localparam logic [P_W-1:0] COS_COEF [6] = '{
        33'd5298703516,
        33'd4358008962,
        33'd1433727481,
        33'd252684340,
        33'd27709939,
        33'd2071865
    };

    // Special-case marks that travel with an item
    typedef struct packed {
        logic zero;   // outside the support: result is 0
        logic sat;    // result is the saturated maximum
    } flags_t;

    function automatic logic [P_W-1:0] sat_sub(input logic [P_W-1:0] a,
                                               input logic [P_W-1:0] b);
        sat_sub = (a > b) ? (a - b) : '0;
    endfunction

endpackage

### hdl/smoothed_dirac_delta_unit.sv
// Smoothed Dirac delta, (1/(2*sigma))*(1+cos(pi*x/sigma)) inside |x| <= sigma and
// zero outside, on Q.FRAC_BITS samples. The unit takes one sample per clock unless
// every stage is full and the output is stalled. Each sample passes through 65
// register stages: the input stage, the 31-stage ratio divider, the 8-stage cosine
// unit, the overflow stage, the 23-stage output divider and the output register,
// with one quotient bit per divider stage and at most one multiply per cosine stage.
// A stalled output backs up the pipeline stage by stage, so empty stages still take
// new samples. Write sigma only while no sample is inside the unit.
module smoothed_dirac_delta_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sigma_valid,
    output logic                          sigma_ready,
    input  logic [sdd_pkg::SIGMA_W-1:0]   sigma,
    input  logic                          phi_valid,
    output logic                          phi_ready,
    input  logic signed [sdd_pkg::PHI_W-1:0] phi_value,
    output logic                          delta_valid,
    input  logic                          delta_ready,
    output logic [sdd_pkg::OUT_W-1:0]     delta_value
);
    import sdd_pkg::*;

    // Scaling of the output divide: c * 2^(2F) / (2^31 * sigma)
    localparam int NUM_SH  = (2 * FRAC_BITS >= 31) ? (2 * FRAC_BITS - 31) : 0;
    localparam int DEN_SH  = (2 * FRAC_BITS < 31) ? (31 - 2 * FRAC_BITS) : 0;
    localparam int NUM2_W  = C_W + NUM_SH;
    localparam int DEN2_W  = SIGMA_W + DEN_SH;
    localparam int CMP_W   = (NUM2_W > DEN2_W + OUT_W) ? NUM2_W : DEN2_W + OUT_W;
    localparam int NUM1_W  = SIGMA_W + Q_FRAC;

    // Stage map
    localparam int DIV1_BASE = 1;
    localparam int COS_BASE  = DIV1_BASE + R_W;
    localparam int ST_OVF    = COS_BASE + COS_STG;
    localparam int DIV2_BASE = ST_OVF + 1;
    localparam int ST_OUT    = DIV2_BASE + OUT_W;
    localparam int N_STG     = ST_OUT + 1;

    logic [SIGMA_W-1:0] sigma_reg;
    logic [N_STG-1:0]   v_reg;
    logic [N_STG-1:0]   v_next;
    logic [N_STG-1:0]   en;

    logic [SIGMA_W-1:0] mag_reg;
    flags_t             fl0_reg;
    logic [NUM2_W-1:0]  n2_reg;
    flags_t             fl_ovf_reg;
    logic [OUT_W-1:0]   delta_value_reg;

    logic [PHI_W-1:0]   mag;
    logic               out_zero;
    logic               out_sat;
    flags_t             fl0_next;
    logic [R_W-1:0]     ratio;
    flags_t             fl_div1;
    logic [C_W-1:0]     one_cos;
    flags_t             fl_cos;
    logic [NUM2_W-1:0]  n2_next;
    logic [DEN2_W-1:0]  den2;
    logic               ovf;
    flags_t             fl_ovf_next;
    logic [OUT_W-1:0]   quo2;
    flags_t             fl_div2;
    logic [OUT_W-1:0]   delta_next;

    // Configuration register
    assign sigma_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sigma_reg <= SIGMA_RESET;
        end
        else if (sigma_valid)
        begin
            sigma_reg <= sigma;
        end
    end

    // Stage enables: a stage advances when the consumer is ready or any stage at or after it is empty
    genvar i;
    generate
        for (i = 0; i < N_STG; i++)
        begin : g_en
            assign en[i] = delta_ready | ~(&v_reg[N_STG-1:i]);
        end
    endgenerate

    assign v_next = (en & {v_reg[N_STG-2:0], phi_valid}) | (~en & v_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign phi_ready   = en[0];
    assign delta_valid = v_reg[N_STG-1];

    // Front: magnitude and support test
    assign mag      = phi_value[PHI_W-1] ? PHI_W'(-phi_value) : PHI_W'(phi_value);
    assign out_zero = (mag > {1'b0, sigma_reg});
    assign out_sat  = !out_zero && (sigma_reg == '0);
    assign fl0_next = '{zero: out_zero, sat: out_sat};

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            mag_reg <= (out_zero || out_sat) ? '0 : mag[SIGMA_W-1:0];
            fl0_reg <= fl0_next;
        end
    end

    // Ratio |x| / sigma in Q1.30
    sdd_div_pipe #(
        .NUM_W (NUM1_W),
        .DEN_W (SIGMA_W),
        .QUO_W (R_W),
        .SB_W  ($bits(flags_t))
    ) u_div_ratio (
        .clk    (clk),
        .en     (en[DIV1_BASE +: R_W]),
        .num    ({mag_reg, {Q_FRAC{1'b0}}}),
        .den    (sigma_reg),
        .sb_in  (fl0_reg),
        .quo    (ratio),
        .sb_out (fl_div1)
    );

    // 1 +/- cos(pi * ratio)
    sdd_cos_pipe u_cos (
        .clk       (clk),
        .en        (en[COS_BASE +: COS_STG]),
        .ratio     (ratio),
        .flags_in  (fl_div1),
        .one_cos   (one_cos),
        .flags_out (fl_cos)
    );

    // Scale the numerator and flag a quotient past the output range
    assign n2_next = NUM2_W'(one_cos) << NUM_SH;
    assign den2    = DEN2_W'(sigma_reg) << DEN_SH;
    assign ovf     = (CMP_W'(n2_next) >= CMP_W'({den2, {OUT_W{1'b0}}}));
    assign fl_ovf_next = '{zero: fl_cos.zero, sat: fl_cos.sat | ovf};

    always_ff @(posedge clk)
    begin
        if (en[ST_OVF])
        begin
            n2_reg     <= n2_next;
            fl_ovf_reg <= fl_ovf_next;
        end
    end

    // Output divide
    sdd_div_pipe #(
        .NUM_W (NUM2_W),
        .DEN_W (DEN2_W),
        .QUO_W (OUT_W),
        .SB_W  ($bits(flags_t))
    ) u_div_out (
        .clk    (clk),
        .en     (en[DIV2_BASE +: OUT_W]),
        .num    (n2_reg),
        .den    (den2),
        .sb_in  (fl_ovf_reg),
        .quo    (quo2),
        .sb_out (fl_div2)
    );

    // Select the result and hold it for the consumer
    assign delta_next = fl_div2.zero ? '0 : (fl_div2.sat ? OUT_MAX : quo2);

    always_ff @(posedge clk)
    begin
        if (en[ST_OUT])
        begin
            delta_value_reg <= delta_next;
        end
    end

    assign delta_value = delta_value_reg;

endmodule

### hdl/sdd_div_pipe.sv
module sdd_div_pipe #(
    parameter int NUM_W = 53,
    parameter int DEN_W = 23,
    parameter int QUO_W = 31,
    parameter int SB_W  = 2
) (
    input  logic             clk,
    input  logic [QUO_W-1:0] en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic [SB_W-1:0]  sb_in,
    output logic [QUO_W-1:0] quo,
    output logic [SB_W-1:0]  sb_out
);

    // One quotient bit per stage, restoring form; the caller guarantees
    // that the numerator's top bits are already below the divisor.
    logic [DEN_W-1:0] rem_reg  [QUO_W];
    logic [QUO_W-1:0] quo_reg  [QUO_W];
    logic [QUO_W-1:0] nbit_reg [QUO_W];
    logic [SB_W-1:0]  sb_reg   [QUO_W];

    logic [DEN_W-1:0] rem_in  [QUO_W];
    logic [QUO_W-1:0] quo_in  [QUO_W];
    logic [QUO_W-1:0] nbit_in [QUO_W];
    logic [SB_W-1:0]  sb_in_s [QUO_W];

    logic [DEN_W-1:0] rem_next  [QUO_W];
    logic [QUO_W-1:0] quo_next  [QUO_W];
    logic [QUO_W-1:0] nbit_next [QUO_W];

    genvar s;
    generate
        for (s = 0; s < QUO_W; s++)
        begin : g_stage
            logic [DEN_W:0] trial;
            logic           ge;

            // Pick the stage input
            if (s == 0)
            begin : g_first
                assign rem_in[s]  = DEN_W'(num >> QUO_W);
                assign quo_in[s]  = '0;
                assign nbit_in[s] = num[QUO_W-1:0];
                assign sb_in_s[s] = sb_in;
            end
            else
            begin : g_rest
                assign rem_in[s]  = rem_reg[s-1];
                assign quo_in[s]  = quo_reg[s-1];
                assign nbit_in[s] = nbit_reg[s-1];
                assign sb_in_s[s] = sb_reg[s-1];
            end

            // Shift in the next numerator bit and try the subtract
            assign trial        = {rem_in[s], nbit_in[s][QUO_W-1]};
            assign ge           = (trial >= {1'b0, den});
            assign rem_next[s]  = ge ? DEN_W'(trial - {1'b0, den}) : DEN_W'(trial);
            assign quo_next[s]  = {quo_in[s][QUO_W-2:0], ge};
            assign nbit_next[s] = nbit_in[s] << 1;

            always_ff @(posedge clk)
            begin
                if (en[s])
                begin
                    rem_reg[s]  <= rem_next[s];
                    quo_reg[s]  <= quo_next[s];
                    nbit_reg[s] <= nbit_next[s];
                    sb_reg[s]   <= sb_in_s[s];
                end
            end
        end
    endgenerate

    assign quo    = quo_reg[QUO_W-1];
    assign sb_out = sb_reg[QUO_W-1];

endmodule

### hdl/sdd_cos_pipe.sv
module sdd_cos_pipe (
    input  logic                                clk,
    input  logic [sdd_pkg::COS_STG-1:0]         en,
    input  logic [sdd_pkg::R_W-1:0]             ratio,
    input  sdd_pkg::flags_t                     flags_in,
    output logic [sdd_pkg::C_W-1:0]             one_cos,
    output sdd_pkg::flags_t                     flags_out
);
    import sdd_pkg::*;

    localparam int PROD_W = V_W + P_W;

    logic [U_W-1:0] u_reg;
    logic [V_W-1:0] v_reg   [1:6];
    logic [P_W-1:0] p_reg   [2:6];
    logic           neg_reg [0:6];
    flags_t         fl_reg  [0:7];
    logic [C_W-1:0] c_reg;

    logic           neg_next;
    logic [U_W-1:0] u_next;
    logic [2*U_W-1:0] sq;
    logic [P_W-1:0] p_next  [2:6];
    logic [PROD_W-1:0] prod_last;
    logic [P_W-1:0] t_last;
    logic [P_W-1:0] t_clamp;
    logic [C_W-1:0] c_next;

    // Fold the ratio into the first quarter turn
    assign neg_next = (ratio > Q30_HALF);
    assign u_next   = neg_next ? U_W'(Q30_ONE[R_W-1:0] - ratio) : U_W'(ratio);

    // Square of the folded ratio
    assign sq = u_reg * u_reg;

    // Horner steps, highest coefficient first
    genvar s;
    generate
        for (s = 2; s <= 6; s++)
        begin : g_horner
            logic [P_W-1:0]    p_prev;
            logic [PROD_W-1:0] prod;
            if (s == 2)
            begin : g_seed
                assign p_prev = COS_COEF[5];
            end
            else
            begin : g_chain
                assign p_prev = p_reg[s-1];
            end
            assign prod      = v_reg[s-1] * p_prev;
            assign p_next[s] = sat_sub(COS_COEF[6-s], P_W'(prod >> Q_FRAC));
        end
    endgenerate

    // Last step, clamp, and form 1 +/- cos
    assign prod_last = v_reg[6] * p_reg[6];
    assign t_last    = sat_sub(Q30_ONE, P_W'(prod_last >> Q_FRAC));
    assign t_clamp   = (t_last > Q30_ONE) ? Q30_ONE : t_last;
    assign c_next    = neg_reg[6] ? C_W'(Q30_ONE - t_clamp) : C_W'(Q30_ONE + t_clamp);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            u_reg      <= u_next;
            neg_reg[0] <= neg_next;
            fl_reg[0]  <= flags_in;
        end
        if (en[1])
        begin
            v_reg[1] <= V_W'(sq >> Q_FRAC);
        end
        for (int k = 1; k <= 6; k++)
        begin
            if (en[k])
            begin
                neg_reg[k] <= neg_reg[k-1];
            end
        end
        for (int k = 1; k <= 7; k++)
        begin
            if (en[k])
            begin
                fl_reg[k] <= fl_reg[k-1];
            end
        end
        for (int k = 2; k <= 6; k++)
        begin
            if (en[k])
            begin
                v_reg[k] <= v_reg[k-1];
                p_reg[k] <= p_next[k];
            end
        end
        if (en[7])
        begin
            c_reg <= c_next;
        end
    end

    assign one_cos   = c_reg;
    assign flags_out = fl_reg[7];

endmodule

### hdl/sdd_checker.sv
module sdd_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          sigma_valid,
    input logic                          sigma_ready,
    input logic                          phi_valid,
    input logic                          phi_ready,
    input logic                          delta_valid,
    input logic                          delta_ready,
    input logic [sdd_pkg::OUT_W-1:0]     delta_value
);

    // A waiting item holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        delta_valid && !delta_ready |=> delta_valid && $stable(delta_value))
        else $error("delta item changed while stalled");

    // An empty or draining output end lets an item in
    a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (!delta_valid || delta_ready) |-> phi_ready)
        else $error("input stalled while output end is free");

    // Pipeline comes out of reset empty
    a_empty_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !delta_valid)
        else $error("item present right after reset");

    // Configuration writes never stall
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        sigma_valid |-> sigma_ready)
        else $error("sigma write stalled");

endmodule

bind smoothed_dirac_delta_unit sdd_checker u_sdd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .sigma_valid (sigma_valid),
    .sigma_ready (sigma_ready),
    .phi_valid   (phi_valid),
    .phi_ready   (phi_ready),
    .delta_valid (delta_valid),
    .delta_ready (delta_ready),
    .delta_value (delta_value)
);
